@@ rtl/fcc_pkg.sv @@
package fcc_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ATAN_LEN             = 24;
    localparam int WHEEL_SIZE           = 55;
    localparam int SQRT_STEPS           = 21;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_COLOR = 2'd2;

    localparam logic signed [15:0] THRESHOLD_RST     = 16'sd32767;
    localparam logic [15:0]        INVERSE_RST       = 16'd4096;
    localparam logic [7:0]         UNKNOWN_COLOR_RST = 8'd0;

    localparam logic [23:0] COLOR_FULL = 24'hFF0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // {red, green, blue}
    localparam logic [23:0] WHEEL [WHEEL_SIZE] = '{
        {8'd255, 8'd0, 8'd0},   {8'd255, 8'd17, 8'd0},  {8'd255, 8'd34, 8'd0},
        {8'd255, 8'd51, 8'd0},  {8'd255, 8'd68, 8'd0},  {8'd255, 8'd85, 8'd0},
        {8'd255, 8'd102, 8'd0}, {8'd255, 8'd119, 8'd0}, {8'd255, 8'd136, 8'd0},
        {8'd255, 8'd153, 8'd0}, {8'd255, 8'd170, 8'd0}, {8'd255, 8'd187, 8'd0},
        {8'd255, 8'd204, 8'd0}, {8'd255, 8'd221, 8'd0}, {8'd255, 8'd238, 8'd0},
        {8'd255, 8'd255, 8'd0}, {8'd213, 8'd255, 8'd0}, {8'd170, 8'd255, 8'd0},
        {8'd128, 8'd255, 8'd0}, {8'd85, 8'd255, 8'd0},  {8'd43, 8'd255, 8'd0},
        {8'd0, 8'd255, 8'd0},   {8'd0, 8'd255, 8'd63},  {8'd0, 8'd255, 8'd127},
        {8'd0, 8'd255, 8'd191},
        {8'd0, 8'd255, 8'd255}, {8'd0, 8'd232, 8'd255}, {8'd0, 8'd209, 8'd255},
        {8'd0, 8'd186, 8'd255}, {8'd0, 8'd163, 8'd255}, {8'd0, 8'd140, 8'd255},
        {8'd0, 8'd116, 8'd255}, {8'd0, 8'd93, 8'd255},  {8'd0, 8'd70, 8'd255},
        {8'd0, 8'd47, 8'd255},  {8'd0, 8'd24, 8'd255},
        {8'd0, 8'd0, 8'd255},   {8'd19, 8'd0, 8'd255},  {8'd39, 8'd0, 8'd255},
        {8'd58, 8'd0, 8'd255},  {8'd78, 8'd0, 8'd255},  {8'd98, 8'd0, 8'd255},
        {8'd117, 8'd0, 8'd255}, {8'd137, 8'd0, 8'd255}, {8'd156, 8'd0, 8'd255},
        {8'd176, 8'd0, 8'd255}, {8'd196, 8'd0, 8'd255}, {8'd215, 8'd0, 8'd255},
        {8'd235, 8'd0, 8'd255},
        {8'd255, 8'd0, 8'd255}, {8'd255, 8'd0, 8'd213}, {8'd255, 8'd0, 8'd170},
        {8'd255, 8'd0, 8'd128}, {8'd255, 8'd0, 8'd85},  {8'd255, 8'd0, 8'd43}
    };

endpackage

@@ rtl/fcc_flow_if.sv @@
interface fcc_flow_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;

    modport source (output valid, output flow_x, output flow_y, input ready);
    modport sink (input valid, input flow_x, input flow_y, output ready);
endinterface

@@ rtl/fcc_color_if.sv @@
interface fcc_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       unknown;

    modport source (output valid, output red, output green, output blue, output unknown,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input unknown,
                  output ready);
endinterface

@@ rtl/flow_color_coding_top.sv @@
// stages: classify, scale, squares and cordic prerotation, iterative stages, wheel
// position, blend, radius pull, output register; each iterative stage does at most
// one cordic iteration and one root bit; throughput: one request per cycle,
// but the whole pipeline holds while the output register is full and not taken
// reset: synchronous active low, clears all valid bits and loads register defaults
module flow_color_coding_top #(
    parameter int ANGLE_ITERATIONS = fcc_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fcc_flow_if.sink                        i_flow,
    fcc_color_if.source                     o_color
);

    localparam int K  = (ANGLE_ITERATIONS > fcc_pkg::SQRT_STEPS) ?
                        ANGLE_ITERATIONS : fcc_pkg::SQRT_STEPS;
    localparam int CW = 36;

    typedef struct packed {
        logic                 unk;
        logic                 special;
        logic                 in_unit;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic [41:0]          v;
        logic [23:0]          rem;
        logic [20:0]          root;
    } t_stage;

    // configuration
    logic signed [15:0] r_thresh;
    logic [15:0]        r_inv;
    logic [7:0]         r_ucol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= fcc_pkg::THRESHOLD_RST;
            r_inv    <= fcc_pkg::INVERSE_RST;
            r_ucol   <= fcc_pkg::UNKNOWN_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fcc_pkg::CFG_THRESHOLD:     r_thresh <= $signed(i_cfg_data);
                fcc_pkg::CFG_INVERSE:       r_inv    <= i_cfg_data;
                fcc_pkg::CFG_UNKNOWN_COLOR: r_ucol   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    logic w_adv;
    logic r_out_vld;

    assign w_adv        = !r_out_vld || o_color.ready;
    assign i_flow.ready = w_adv;

    // stage 1: classify
    logic               r1_vld, r1_unk;
    logic signed [15:0] r1_fx, r1_fy;

    // stage 2: scale
    logic               r2_vld, r2_unk;
    logic signed [32:0] r2_sx, r2_sy;

    // stage 3: squares and cordic prerotation
    logic                 r3_vld, r3_unk, r3_special;
    logic [63:0]          r3_sqx, r3_sqy;
    logic signed [CW-1:0] r3_x, r3_y;
    logic [31:0]          r3_z;

    logic [31:0]          w_ax, w_ay;
    logic signed [CW-1:0] w_x0, w_y0;
    logic [63:0]          w_sum;

    always_comb begin
        w_ax  = r2_sx[32] ? 32'(-r2_sx) : r2_sx[31:0];
        w_ay  = r2_sy[32] ? 32'(-r2_sy) : r2_sy[31:0];
        w_x0  = {{(CW-33){r2_sy[32]}}, r2_sy};
        w_y0  = {{(CW-33){r2_sx[32]}}, r2_sx};
        w_sum = r3_sqx + r3_sqy;
    end

    // iterative section
    logic [K:0] r_vld;
    t_stage     r_st [K+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_vld  <= '0;
        end else if (w_adv) begin
            r1_vld <= i_flow.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r_vld  <= {r_vld[K-1:0], r3_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_fx  <= i_flow.flow_x;
            r1_fy  <= i_flow.flow_y;
            r1_unk <= (i_flow.flow_x >= r_thresh) || (i_flow.flow_y >= r_thresh);

            r2_unk <= r1_unk;
            r2_sx  <= r1_fx * $signed({1'b0, r_inv});
            r2_sy  <= r1_fy * $signed({1'b0, r_inv});

            r3_unk     <= r2_unk;
            r3_sqx     <= {32'd0, w_ax} * {32'd0, w_ax};
            r3_sqy     <= {32'd0, w_ay} * {32'd0, w_ay};
            r3_special <= (r2_sx == '0) && r2_sy[32];
            if (w_x0 < 0) begin
                r3_x <= -w_x0;
                r3_y <= -w_y0;
                r3_z <= 32'h8000_0000;
            end else begin
                r3_x <= w_x0;
                r3_y <= w_y0;
                r3_z <= 32'd0;
            end

            r_st[0].unk     <= r3_unk;
            r_st[0].special <= r3_special;
            r_st[0].in_unit <= w_sum <= 64'h0000_0100_0000_0000;
            r_st[0].x       <= r3_x;
            r_st[0].y       <= r3_y;
            r_st[0].z       <= r3_z;
            r_st[0].v       <= w_sum[41:0];
            r_st[0].rem     <= '0;
            r_st[0].root    <= '0;
        end
    end

    for (genvar k = 0; k < K; k++) begin : g_stage
        t_stage               n_st;
        logic signed [CW-1:0] w_dx, w_dy;
        logic [23:0]          w_r2, w_trial;

        always_comb begin
            n_st    = r_st[k];
            w_dx    = $signed(r_st[k].y) >>> k;
            w_dy    = $signed(r_st[k].x) >>> k;
            w_r2    = {r_st[k].rem[21:0], r_st[k].v[41:40]};
            w_trial = {1'b0, r_st[k].root, 2'b01};
            if (k < ANGLE_ITERATIONS) begin
                if ($signed(r_st[k].y) > 0) begin
                    n_st.x = r_st[k].x + w_dx;
                    n_st.y = r_st[k].y - w_dy;
                    n_st.z = r_st[k].z + fcc_pkg::ATAN_TURN[k];
                end else begin
                    n_st.x = r_st[k].x - w_dx;
                    n_st.y = r_st[k].y + w_dy;
                    n_st.z = r_st[k].z - fcc_pkg::ATAN_TURN[k];
                end
            end
            if (k < fcc_pkg::SQRT_STEPS) begin
                n_st.v = {r_st[k].v[39:0], 2'b00};
                if (w_r2 >= w_trial) begin
                    n_st.rem  = w_r2 - w_trial;
                    n_st.root = {r_st[k].root[19:0], 1'b1};
                end else begin
                    n_st.rem  = w_r2;
                    n_st.root = {r_st[k].root[19:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    // stage 5: wheel position
    logic        r5_vld, r5_unk, r5_inside;
    logic [5:0]  r5_k0;
    logic [15:0] r5_f;
    logic [20:0] r5_rad;
    logic [32:0] w_t;
    logic [38:0] w_fk;

    always_comb begin
        w_t  = r_st[K].special ? 33'h1_0000_0000 :
               {1'b0, ~r_st[K].z[31], r_st[K].z[30:0]};
        w_fk = {6'd0, w_t} * 39'd54;
    end

    // stage 6: blend
    logic        r6_vld, r6_unk, r6_inside;
    logic [20:0] r6_rad;
    logic [23:0] r6_c [3];
    logic [5:0]  w_k1;
    logic [23:0] w_e0, w_e1;
    logic [16:0] w_nf;
    logic [24:0] w_mix [3];

    always_comb begin
        w_k1 = (r5_k0 == 6'(fcc_pkg::WHEEL_SIZE - 1)) ? 6'd0 : r5_k0 + 6'd1;
        w_e0 = fcc_pkg::WHEEL[r5_k0];
        w_e1 = fcc_pkg::WHEEL[w_k1];
        w_nf = 17'h10000 - {1'b0, r5_f};
        for (int b = 0; b < 3; b++) begin
            w_mix[b] = ({8'd0, w_nf} * {17'd0, w_e0[23-8*b -: 8]}) +
                       ({9'd0, r5_f} * {17'd0, w_e1[23-8*b -: 8]});
        end
    end

    // stage 7: radius pull and outer scale
    logic        r7_vld, r7_unk, r7_inside;
    logic [23:0] r7_pull [3];
    logic [7:0]  r7_outv [3];
    logic [44:0] w_prod [3];
    logic [25:0] w_three [3];

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            w_prod[b]  = {24'd0, r6_rad} * {21'd0, fcc_pkg::COLOR_FULL - r6_c[b]};
            w_three[b] = {2'd0, r6_c[b]} * 26'd3;
        end
    end

    // output register
    logic        r_out_unk;
    logic [7:0]  r_out_ch [3];
    logic [23:0] w_rem [3];
    logic [7:0]  w_ch [3];

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            w_rem[b] = fcc_pkg::COLOR_FULL - r7_pull[b];
            w_ch[b]  = r7_unk ? r_ucol : (r7_inside ? w_rem[b][23:16] : r7_outv[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld    <= r_vld[K];
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r_out_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_unk    <= r_st[K].unk;
            r5_inside <= r_st[K].in_unit;
            r5_rad    <= r_st[K].root;
            r5_k0     <= w_fk[37:32];
            r5_f      <= w_fk[31:16];

            r6_unk    <= r5_unk;
            r6_inside <= r5_inside;
            r6_rad    <= r5_rad;
            r7_unk    <= r6_unk;
            r7_inside <= r6_inside;
            r_out_unk <= r7_unk;
            for (int b = 0; b < 3; b++) begin
                r6_c[b]     <= w_mix[b][23:0];
                r7_pull[b]  <= w_prod[b][43:20];
                r7_outv[b]  <= w_three[b][25:18];
                r_out_ch[b] <= w_ch[b];
            end
        end
    end

    assign o_color.valid   = r_out_vld;
    assign o_color.red     = r_out_ch[0];
    assign o_color.green   = r_out_ch[1];
    assign o_color.blue    = r_out_ch[2];
    assign o_color.unknown = r_out_unk;

    a_wheel_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld && !r5_unk |-> r5_k0 <= 6'(fcc_pkg::WHEEL_SIZE - 1))
        else $error("wheel index beyond last entry");

    a_radius_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[K] && !r_st[K].unk && r_st[K].in_unit |-> r_st[K].root <= 21'h100000)
        else $error("radius above unit inside the unit circle");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld) && $stable(r7_vld))
        else $error("pipeline moved while stalled");

endmodule
